FILE: rtl/rpc_pkg.sv
package rpc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int NUM_CELLS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int STAGE_W = $clog2(ATAN_ENTRIES);
  localparam int CW = 33;

  localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30 = 33'sd1073741824;
  localparam logic signed [CW-1:0] MINUS_ONE_Q30 = -33'sd1073741824;
  localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;
  localparam logic [15:0] EIGHTH_TURN = 16'h2000;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [15:0]        turn_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [1:0]         quadrant;
  } carry_t;

  typedef struct packed {
    carry_t              carry;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cell_data_t;

  // Arctangent of 2^-i in units of 2^-32 turn, rounded to nearest.
  function automatic logic signed [CW-1:0] atan_turn(input logic [STAGE_W-1:0] idx);
    logic signed [CW-1:0] val;
    unique case (idx)
      5'd0:    val = 33'sd536870912;
      5'd1:    val = 33'sd316933406;
      5'd2:    val = 33'sd167458907;
      5'd3:    val = 33'sd85004756;
      5'd4:    val = 33'sd42667331;
      5'd5:    val = 33'sd21354465;
      5'd6:    val = 33'sd10679838;
      5'd7:    val = 33'sd5340245;
      5'd8:    val = 33'sd2670163;
      5'd9:    val = 33'sd1335087;
      5'd10:   val = 33'sd667544;
      5'd11:   val = 33'sd333772;
      5'd12:   val = 33'sd166886;
      5'd13:   val = 33'sd83443;
      5'd14:   val = 33'sd41722;
      5'd15:   val = 33'sd20861;
      5'd16:   val = 33'sd10430;
      5'd17:   val = 33'sd5215;
      5'd18:   val = 33'sd2608;
      5'd19:   val = 33'sd1304;
      5'd20:   val = 33'sd652;
      5'd21:   val = 33'sd326;
      5'd22:   val = 33'sd163;
      5'd23:   val = 33'sd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/rpc_prep.sv
module rpc_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  input  rpc_pkg::in_item_t   up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output rpc_pkg::cell_data_t dn_data,
  input  logic                dn_ready
);
  import rpc_pkg::*;

  logic [15:0]  angle_sum;
  logic [1:0]   quadrant;
  logic [15:0]  residual;
  cell_data_t   dn_data_next;

  always_comb begin
    angle_sum = up_data.turn_angle + EIGHTH_TURN;
    quadrant = angle_sum[15:14];
    residual = up_data.turn_angle - {quadrant, 14'd0};
    dn_data_next.carry.center_x = up_data.center_x;
    dn_data_next.carry.center_y = up_data.center_y;
    dn_data_next.carry.dx = $signed({up_data.point_x[31], up_data.point_x})
                          - $signed({up_data.center_x[31], up_data.center_x});
    dn_data_next.carry.dy = $signed({up_data.point_y[31], up_data.point_y})
                          - $signed({up_data.center_y[31], up_data.center_y});
    dn_data_next.carry.quadrant = quadrant;
    dn_data_next.x = GAIN_Q30;
    dn_data_next.y = '0;
    dn_data_next.z = $signed({residual[15], residual, 16'd0});
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= dn_data_next;
    end
  end

endmodule

FILE: rtl/rpc_cordic_cell.sv
module rpc_cordic_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rpc_pkg::STAGE_W-1:0]   stage_idx,
  input  logic                          up_valid,
  input  rpc_pkg::cell_data_t           up_data,
  output logic                          up_ready,
  output logic                          dn_valid,
  output rpc_pkg::cell_data_t           dn_data,
  input  logic                          dn_ready
);
  import rpc_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] atan_val;
  cell_data_t           dn_data_next;

  always_comb begin
    xs = $signed(up_data.x) >>> stage_idx;
    ys = $signed(up_data.y) >>> stage_idx;
    atan_val = atan_turn(stage_idx);
    dn_data_next.carry = up_data.carry;
    if (!up_data.z[CW-1]) begin
      dn_data_next.x = up_data.x - ys;
      dn_data_next.y = up_data.y + xs;
      dn_data_next.z = up_data.z - atan_val;
    end else begin
      dn_data_next.x = up_data.x + ys;
      dn_data_next.y = up_data.y - xs;
      dn_data_next.z = up_data.z + atan_val;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= dn_data_next;
    end
  end

endmodule

FILE: rtl/rpc_back.sv
module rpc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  input  rpc_pkg::cell_data_t up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output rpc_pkg::out_item_t  dn_data,
  input  logic                dn_ready
);
  import rpc_pkg::*;

  logic v1, v2, v3;
  logic r1, r2, r3, r4;

  logic signed [CW-1:0] cos_raw;
  logic signed [CW-1:0] sin_raw;
  logic signed [CW-1:0] cos_next;
  logic signed [CW-1:0] sin_next;

  logic signed [31:0] b1_cos;
  logic signed [31:0] b1_sin;
  logic signed [32:0] b1_dx;
  logic signed [32:0] b1_dy;
  logic signed [31:0] b1_cx;
  logic signed [31:0] b1_cy;

  logic signed [64:0] p_xc;
  logic signed [64:0] p_ys;
  logic signed [64:0] p_yc;
  logic signed [64:0] p_xs;
  logic signed [31:0] b2_cx;
  logic signed [31:0] b2_cy;

  logic signed [65:0] sum_x;
  logic signed [65:0] sum_y;
  logic signed [35:0] b3_rx;
  logic signed [35:0] b3_ry;
  logic signed [31:0] b3_cx;
  logic signed [31:0] b3_cy;

  logic signed [36:0] tot_x;
  logic signed [36:0] tot_y;
  out_item_t          dn_data_next;

  function automatic logic signed [CW-1:0] clamp_unit(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] res;
    if (v > ONE_Q30) begin
      res = ONE_Q30;
    end else if (v < MINUS_ONE_Q30) begin
      res = MINUS_ONE_Q30;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] res;
    if (!v[36] && (|v[35:31])) begin
      res = 32'sh7FFFFFFF;
    end else if (v[36] && !(&v[35:31])) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  always_comb begin
    unique case (up_data.carry.quadrant)
      2'd0: begin
        cos_raw = up_data.x;
        sin_raw = up_data.y;
      end
      2'd1: begin
        cos_raw = -up_data.y;
        sin_raw = up_data.x;
      end
      2'd2: begin
        cos_raw = -up_data.x;
        sin_raw = -up_data.y;
      end
      2'd3: begin
        cos_raw = up_data.y;
        sin_raw = -up_data.x;
      end
    endcase
    cos_next = clamp_unit(cos_raw);
    sin_next = clamp_unit(sin_raw);
  end

  always_comb begin
    sum_x = $signed({p_xc[64], p_xc}) - $signed({p_ys[64], p_ys}) + ROUND_HALF;
    sum_y = $signed({p_yc[64], p_yc}) + $signed({p_xs[64], p_xs}) + ROUND_HALF;
  end

  always_comb begin
    tot_x = $signed({{5{b3_cx[31]}}, b3_cx}) + $signed({b3_rx[35], b3_rx});
    tot_y = $signed({{5{b3_cy[31]}}, b3_cy}) + $signed({b3_ry[35], b3_ry});
    dn_data_next.rotated_x = sat32(tot_x);
    dn_data_next.rotated_y = sat32(tot_y);
  end

  assign r4 = !dn_valid || dn_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign up_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= up_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r4) begin
        dn_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && up_valid) begin
      b1_cos <= cos_next[31:0];
      b1_sin <= sin_next[31:0];
      b1_dx <= up_data.carry.dx;
      b1_dy <= up_data.carry.dy;
      b1_cx <= up_data.carry.center_x;
      b1_cy <= up_data.carry.center_y;
    end
    if (r2 && v1) begin
      p_xc <= $signed(b1_dx) * $signed(b1_cos);
      p_ys <= $signed(b1_dy) * $signed(b1_sin);
      p_yc <= $signed(b1_dy) * $signed(b1_cos);
      p_xs <= $signed(b1_dx) * $signed(b1_sin);
      b2_cx <= b1_cx;
      b2_cy <= b1_cy;
    end
    if (r3 && v2) begin
      b3_rx <= sum_x[65:30];
      b3_ry <= sum_y[65:30];
      b3_cx <= b2_cx;
      b3_cy <= b2_cy;
    end
    if (r4 && v3) begin
      dn_data <= dn_data_next;
    end
  end

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (b1_cos <= 32'sd1073741824) && (b1_cos >= -32'sd1073741824)
        && (b1_sin <= 32'sd1073741824) && (b1_sin >= -32'sd1073741824))
    else $error("cosine or sine out of unit range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !v1 && !v2 && !v3 && !dn_valid)
    else $error("pipeline not empty after reset");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v3 && r4) |=> dn_valid)
    else $error("item lost between last stages");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !r2) |=> v1 && $stable(b1_cos) && $stable(b1_dx))
    else $error("blocked stage did not hold its item");

endmodule

FILE: rtl/rotate_point_about_center.sv
// Pipeline: the prep register, one registered CORDIC cell per stage (NUM_CELLS, 16 by default),
// then the back-end stages b1 (cosine/sine), p (products), b3 (sums) and the output register.
// Throughput: one item per cycle while result_stall is low; every stage is a registered
// cell with its own valid bit, and a stalled result only blocks stages that are full.
// Reset (synchronous, active high) clears all valid bits; payload registers are not reset.
module rotate_point_about_center (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_stall,
  input  rpc_pkg::in_item_t  point_item,
  output logic               result_valid,
  input  logic               result_stall,
  output rpc_pkg::out_item_t result_item
);
  import rpc_pkg::*;

  logic       chain_valid [NUM_CELLS+1];
  logic       chain_ready [NUM_CELLS+1];
  cell_data_t chain_data  [NUM_CELLS+1];
  logic       prep_ready;

  assign point_stall = !prep_ready;

  rpc_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (point_valid),
    .up_data  (point_item),
    .up_ready (prep_ready),
    .dn_valid (chain_valid[0]),
    .dn_data  (chain_data[0]),
    .dn_ready (chain_ready[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    rpc_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_idx (STAGE_W'(k)),
      .up_valid  (chain_valid[k]),
      .up_data   (chain_data[k]),
      .up_ready  (chain_ready[k]),
      .dn_valid  (chain_valid[k+1]),
      .dn_data   (chain_data[k+1]),
      .dn_ready  (chain_ready[k+1])
    );
  end

  rpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[NUM_CELLS]),
    .up_data  (chain_data[NUM_CELLS]),
    .up_ready (chain_ready[NUM_CELLS]),
    .dn_valid (result_valid),
    .dn_data  (result_item),
    .dn_ready (!result_stall)
  );

endmodule
